// ===== src/chip8_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the CHIP-8 core.
package chip8_pkg;

    localparam int ADDR_W     = 12;
    localparam int MEM_BYTES  = 4096;
    localparam int FB_BYTES   = 256;
    localparam int FB_ADDR_W  = 8;
    localparam int FONT_BYTES = 80;

    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_WAIT_KEY = 2'd1;
    localparam logic [1:0] STS_UNKNOWN  = 2'd2;
    localparam logic [1:0] STS_DONE     = 2'd3;

    localparam logic [11:0] PC_RESET = 12'h200;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV  = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_SKP  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [11:0] SYS_CLS = 12'h0E0;
    localparam logic [11:0] SYS_RET = 12'h0EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] MISC_GDT = 8'h07;
    localparam logic [7:0] MISC_KEY = 8'h0A;
    localparam logic [7:0] MISC_SDT = 8'h15;
    localparam logic [7:0] MISC_SST = 8'h18;
    localparam logic [7:0] MISC_ADI = 8'h1E;
    localparam logic [7:0] MISC_FNT = 8'h29;
    localparam logic [7:0] MISC_BCD = 8'h33;
    localparam logic [7:0] MISC_STR = 8'h55;
    localparam logic [7:0] MISC_LDR = 8'h65;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [15:0] key_state;
        logic [7:0]  random_byte;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

// ===== src/chip8_ifs.sv =====
`timescale 1ns / 1ps
// Command and result channel interfaces of the CHIP-8 core.
interface chip8_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] key_state;
    logic [7:0]  random_byte;

    modport source (output valid, command, address, write_data, key_state, random_byte,
                    input ready);
    modport sink (input valid, command, address, write_data, key_state, random_byte,
                  output ready);
endinterface

interface chip8_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] program_counter;
    logic [15:0] index_value;
    logic [1:0]  status;
    logic        beep;
    logic [7:0]  read_data;

    modport source (output valid, program_counter, index_value, status, beep, read_data,
                    input ready);
    modport sink (input valid, program_counter, index_value, status, beep, read_data,
                  output ready);
endinterface

// ===== src/chip8_front.sv =====
`timescale 1ns / 1ps
// Command intake: accepts transfers, tidies the fields and queues them for execution.
module chip8_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    chip8_in_if.sink        i_item,
    input  logic            i_enable,
    input  logic            i_pop,
    output chip8_pkg::t_head o_head
);
    import chip8_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_item      w_in;

    assign i_item.ready = i_enable && (r_cnt != 2'd2);
    assign w_push       = i_item.valid && i_item.ready;
    assign w_pop        = i_pop && (r_cnt != 2'd0);

    always_comb begin
        w_in.command     = i_item.command;
        w_in.address     = (i_item.command == CMD_READ) ?
                           {4'd0, i_item.address[7:0]} : i_item.address;
        w_in.write_data  = i_item.write_data;
        w_in.key_state   = i_item.key_state;
        w_in.random_byte = i_item.random_byte;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

endmodule

// ===== src/chip8_exec.sv =====
`timescale 1ns / 1ps
// Execution sequencer: memories, registers, timers, sprite drawing and result register.
module chip8_exec #(
    parameter int STACK_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  chip8_pkg::t_head i_head,
    output logic             o_pop,
    output logic             o_enable,
    chip8_out_if.source      o_result
);
    import chip8_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH);

    localparam logic [4:0] S_INIT = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_RD   = 5'd2;
    localparam logic [4:0] S_F1   = 5'd3;
    localparam logic [4:0] S_F2   = 5'd4;
    localparam logic [4:0] S_F3   = 5'd5;
    localparam logic [4:0] S_F4   = 5'd6;
    localparam logic [4:0] S_EX   = 5'd7;
    localparam logic [4:0] S_WF   = 5'd8;
    localparam logic [4:0] S_DR0  = 5'd9;
    localparam logic [4:0] S_DR1  = 5'd10;
    localparam logic [4:0] S_DR2  = 5'd11;
    localparam logic [4:0] S_DR3  = 5'd12;
    localparam logic [4:0] S_BCD  = 5'd13;
    localparam logic [4:0] S_ST0  = 5'd14;
    localparam logic [4:0] S_ST1  = 5'd15;
    localparam logic [4:0] S_LD0  = 5'd16;
    localparam logic [4:0] S_LD1  = 5'd17;

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  rf [16];
    logic [7:0]  fb [FB_BYTES];
    logic [11:0] r_stack [STACK_DEPTH];
    logic [15:0] r_rfv;
    logic [FB_BYTES-1:0] r_fbv;

    logic [7:0]  r_mq, r_rfq, r_fbq;
    logic        r_rfqv, r_fbqv;

    logic [4:0]  r_state, n_state;
    logic [11:0] r_icnt;
    logic [11:0] r_pc, n_pc;
    logic [15:0] r_i, n_i;
    logic [SPW-1:0] r_sp, n_sp;
    logic [7:0]  r_delay, n_delay, r_sound, n_sound;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_op, n_op;
    logic [7:0]  r_vx, n_vx, r_vy, n_vy;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_hit, n_hit, r_flag, n_flag;
    logic [15:0] r_mask, n_mask;
    logic [4:0]  r_row, n_row;
    logic [15:0] r_keys, n_keys;
    logic [7:0]  r_rnd, n_rnd;

    logic        r_ov, n_ov;
    logic [11:0] r_res_pc, n_res_pc;
    logic [15:0] r_res_i, n_res_i;
    logic [1:0]  r_res_st, n_res_st;
    logic        r_res_beep, n_res_beep;
    logic [7:0]  r_res_rd, n_res_rd;

    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata;
    logic        rf_we;
    logic [3:0]  rf_waddr, rf_raddr;
    logic [7:0]  rf_wdata;
    logic        fb_we;
    logic [FB_ADDR_W-1:0] fb_waddr, fb_raddr;
    logic [7:0]  fb_wdata;
    logic        fbv_clear;
    logic        stack_we;

    logic        done;
    logic [1:0]  d_status;
    logic        d_beep;
    logic [7:0]  d_rd;

    logic [7:0]  rfv_q, fbv_q;
    logic [3:0]  x, y, n;
    logic [7:0]  nn;
    logic [11:0] nnn, pc2, pc4;
    logic [SPW-1:0] sp_dec, sp_inc;
    logic [8:0]  sum9;
    logic [16:0] sum17;
    logic [3:0]  hk;
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] tprod;
    logic [3:0]  tens, ones;
    logic [11:0] i_off;
    logic [2:0]  bx;

    assign rfv_q  = r_rfqv ? r_rfq : 8'd0;
    assign fbv_q  = r_fbqv ? r_fbq : 8'd0;
    assign x      = r_op[11:8];
    assign y      = r_op[7:4];
    assign n      = r_op[3:0];
    assign nn     = r_op[7:0];
    assign nnn    = r_op[11:0];
    assign pc2    = r_pc + 12'd2;
    assign pc4    = r_pc + 12'd4;
    assign sp_dec = (r_sp == '0) ? SPW'(STACK_DEPTH - 1) : r_sp - SPW'(1);
    assign sp_inc = (r_sp == SPW'(STACK_DEPTH - 1)) ? '0 : r_sp + SPW'(1);
    assign sum9   = {1'b0, r_vx} + {1'b0, r_vy};
    assign sum17  = {1'b0, r_i} + {9'd0, r_vx};
    assign i_off  = r_i[11:0] + {8'd0, r_cnt};
    assign bx     = r_vx[5:3];

    always_comb begin
        hk = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (r_keys[k]) begin
                hk = 4'(k);
            end
        end
    end

    always_comb begin
        hund  = (r_vx >= 8'd200) ? 2'd2 : ((r_vx >= 8'd100) ? 2'd1 : 2'd0);
        rem   = 7'(r_vx - 8'(hund) * 8'd100);
        tprod = 15'({8'd0, rem} * 15'd205);
        tens  = tprod[14:11];
        ones  = 4'(rem - 7'(tens) * 7'd10);
    end

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_i        = r_i;
        n_sp       = r_sp;
        n_delay    = r_delay;
        n_sound    = r_sound;
        n_hi       = r_hi;
        n_op       = r_op;
        n_vx       = r_vx;
        n_vy       = r_vy;
        n_cnt      = r_cnt;
        n_hit      = r_hit;
        n_flag     = r_flag;
        n_mask     = r_mask;
        n_row      = r_row;
        n_keys     = r_keys;
        n_rnd      = r_rnd;
        n_ov       = r_ov && !o_result.ready;
        n_res_pc   = r_res_pc;
        n_res_i    = r_res_i;
        n_res_st   = r_res_st;
        n_res_beep = r_res_beep;
        n_res_rd   = r_res_rd;
        mem_we     = 1'b0;
        mem_waddr  = i_off;
        mem_wdata  = 8'd0;
        mem_raddr  = r_pc;
        rf_we      = 1'b0;
        rf_waddr   = x;
        rf_wdata   = 8'd0;
        rf_raddr   = x;
        fb_we      = 1'b0;
        fb_waddr   = {r_row, bx};
        fb_wdata   = 8'd0;
        fb_raddr   = {r_row, bx};
        fbv_clear  = 1'b0;
        stack_we   = 1'b0;
        o_pop      = 1'b0;
        done       = 1'b0;
        d_status   = STS_OK;
        d_beep     = 1'b0;
        d_rd       = 8'd0;

        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_icnt;
                mem_wdata = (r_icnt < 12'(FONT_BYTES)) ? FONT[r_icnt[6:0]] : 8'd0;
                if (r_icnt == 12'hFFF) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid && !r_ov) begin
                    o_pop = 1'b1;
                    unique case (i_head.item.command)
                        CMD_EXEC: begin
                            mem_raddr = r_pc;
                            n_keys    = i_head.item.key_state;
                            n_rnd     = i_head.item.random_byte;
                            n_state   = S_F1;
                        end
                        CMD_TICK: begin
                            if (r_delay != 8'd0) begin
                                n_delay = r_delay - 8'd1;
                            end
                            if (r_sound != 8'd0) begin
                                n_sound = r_sound - 8'd1;
                                d_beep  = (r_sound == 8'd1);
                            end
                            d_status = STS_DONE;
                            done     = 1'b1;
                        end
                        CMD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = i_head.item.address;
                            mem_wdata = i_head.item.write_data;
                            d_status  = STS_DONE;
                            done      = 1'b1;
                        end
                        CMD_READ: begin
                            fb_raddr = i_head.item.address[FB_ADDR_W-1:0];
                            n_state  = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                d_rd     = fbv_q;
                d_status = STS_DONE;
                done     = 1'b1;
                n_state  = S_IDLE;
            end
            S_F1: begin
                n_hi      = r_mq;
                mem_raddr = r_pc + 12'd1;
                n_state   = S_F2;
            end
            S_F2: begin
                n_op     = {r_hi, r_mq};
                rf_raddr = r_hi[3:0];
                n_state  = S_F3;
            end
            S_F3: begin
                n_vx     = rfv_q;
                rf_raddr = (r_op[15:12] == OP_JPV) ? 4'd0 : y;
                n_state  = S_F4;
            end
            S_F4: begin
                n_vy    = rfv_q;
                n_state = S_EX;
            end
            S_EX: begin
                n_pc    = pc2;
                done    = 1'b1;
                n_state = S_IDLE;
                n_cnt   = 4'd0;
                n_hit   = 1'b0;
                unique case (r_op[15:12])
                    OP_SYS: begin
                        if (nnn == SYS_CLS) begin
                            fbv_clear = 1'b1;
                        end else if (nnn == SYS_RET) begin
                            n_sp = sp_dec;
                            n_pc = r_stack[sp_dec] + 12'd2;
                        end else begin
                            d_status = STS_UNKNOWN;
                        end
                    end
                    OP_JP: n_pc = nnn;
                    OP_CALL: begin
                        stack_we = 1'b1;
                        n_sp     = sp_inc;
                        n_pc     = nnn;
                    end
                    OP_SE:   if (r_vx == nn) n_pc = pc4;
                    OP_SNE:  if (r_vx != nn) n_pc = pc4;
                    OP_SER:  if (r_vx == r_vy) n_pc = pc4;
                    OP_SNER: if (r_vx != r_vy) n_pc = pc4;
                    OP_LD: begin
                        rf_we    = 1'b1;
                        rf_wdata = nn;
                    end
                    OP_ADD: begin
                        rf_we    = 1'b1;
                        rf_wdata = r_vx + nn;
                    end
                    OP_ALU: begin
                        rf_we = 1'b1;
                        unique case (n)
                            ALU_MOV: rf_wdata = r_vy;
                            ALU_OR:  rf_wdata = r_vx | r_vy;
                            ALU_AND: rf_wdata = r_vx & r_vy;
                            ALU_XOR: rf_wdata = r_vx ^ r_vy;
                            ALU_ADD: begin
                                rf_wdata = sum9[7:0];
                                n_flag   = sum9[8];
                            end
                            ALU_SUB: begin
                                rf_wdata = r_vx - r_vy;
                                n_flag   = (r_vx >= r_vy);
                            end
                            ALU_SHR: begin
                                rf_wdata = {1'b0, r_vx[7:1]};
                                n_flag   = r_vx[0];
                            end
                            ALU_SUBN: begin
                                rf_wdata = r_vy - r_vx;
                                n_flag   = (r_vy >= r_vx);
                            end
                            ALU_SHL: begin
                                rf_wdata = {r_vx[6:0], 1'b0};
                                n_flag   = r_vx[7];
                            end
                            default: begin
                                rf_we    = 1'b0;
                                d_status = STS_UNKNOWN;
                            end
                        endcase
                        if (rf_we && (n == ALU_ADD || n == ALU_SUB || n == ALU_SHR ||
                                      n == ALU_SUBN || n == ALU_SHL)) begin
                            done    = 1'b0;
                            n_state = S_WF;
                        end
                    end
                    OP_LDI: n_i = {4'd0, nnn};
                    OP_JPV: n_pc = nnn + {4'd0, r_vy};
                    OP_RND: begin
                        rf_we    = 1'b1;
                        rf_wdata = r_rnd & nn;
                    end
                    OP_DRW: begin
                        done    = 1'b0;
                        n_flag  = 1'b0;
                        n_state = (n == 4'd0) ? S_WF : S_DR0;
                    end
                    OP_SKP: begin
                        if (nn == KEY_SKP) begin
                            if (r_keys[r_vx[3:0]]) n_pc = pc4;
                        end else if (nn == KEY_SKNP) begin
                            if (!r_keys[r_vx[3:0]]) n_pc = pc4;
                        end else begin
                            d_status = STS_UNKNOWN;
                        end
                    end
                    OP_MISC: begin
                        unique case (nn)
                            MISC_GDT: begin
                                rf_we    = 1'b1;
                                rf_wdata = r_delay;
                            end
                            MISC_KEY: begin
                                if (r_keys == 16'd0) begin
                                    d_status = STS_WAIT_KEY;
                                end else begin
                                    rf_we    = 1'b1;
                                    rf_wdata = {4'd0, hk};
                                end
                            end
                            MISC_SDT: n_delay = r_vx;
                            MISC_SST: n_sound = r_vx;
                            MISC_ADI: begin
                                n_i     = sum17[15:0];
                                n_flag  = (sum17[16:12] != 5'd0);
                                done    = 1'b0;
                                n_state = S_WF;
                            end
                            MISC_FNT: n_i = {6'd0, r_vx, 2'b00} + {8'd0, r_vx};
                            MISC_BCD: begin
                                done    = 1'b0;
                                n_state = S_BCD;
                            end
                            MISC_STR: begin
                                done    = 1'b0;
                                n_state = S_ST0;
                            end
                            MISC_LDR: begin
                                done    = 1'b0;
                                n_state = S_LD0;
                            end
                            default: d_status = STS_UNKNOWN;
                        endcase
                    end
                    default: ;
                endcase
                if (d_status != STS_OK) begin
                    n_pc = r_pc;
                end
            end
            S_WF: begin
                rf_we    = 1'b1;
                rf_waddr = 4'hF;
                rf_wdata = {7'd0, r_flag};
                done     = 1'b1;
                n_state  = S_IDLE;
            end
            S_DR0: begin
                mem_raddr = i_off;
                n_state   = S_DR1;
            end
            S_DR1: begin
                n_mask   = {r_mq, 8'd0} >> r_vx[2:0];
                n_row    = r_vy[4:0] + {1'b0, r_cnt};
                fb_raddr = {r_vy[4:0] + {1'b0, r_cnt}, bx};
                n_state  = S_DR2;
            end
            S_DR2: begin
                fb_we    = 1'b1;
                fb_waddr = {r_row, bx};
                fb_wdata = fbv_q ^ r_mask[15:8];
                n_hit    = r_hit | ((fbv_q & r_mask[15:8]) != 8'd0);
                fb_raddr = {r_row, bx + 3'd1};
                n_state  = S_DR3;
            end
            S_DR3: begin
                fb_we    = 1'b1;
                fb_waddr = {r_row, bx + 3'd1};
                fb_wdata = fbv_q ^ r_mask[7:0];
                n_hit    = r_hit | ((fbv_q & r_mask[7:0]) != 8'd0);
                if (r_cnt == n - 4'd1) begin
                    n_flag  = n_hit;
                    n_state = S_WF;
                end else begin
                    n_cnt   = r_cnt + 4'd1;
                    n_state = S_DR0;
                end
            end
            S_BCD: begin
                mem_we    = 1'b1;
                mem_waddr = i_off;
                unique case (r_cnt[1:0])
                    2'd0:    mem_wdata = {6'd0, hund};
                    2'd1:    mem_wdata = {4'd0, tens};
                    default: mem_wdata = {4'd0, ones};
                endcase
                if (r_cnt == 4'd2) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_ST0: begin
                rf_raddr = r_cnt;
                n_state  = S_ST1;
            end
            S_ST1: begin
                mem_we    = 1'b1;
                mem_waddr = i_off;
                mem_wdata = rfv_q;
                if (r_cnt == x) begin
                    n_i     = r_i + {12'd0, x} + 16'd1;
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 4'd1;
                    n_state = S_ST0;
                end
            end
            S_LD0: begin
                mem_raddr = i_off;
                n_state   = S_LD1;
            end
            S_LD1: begin
                rf_we    = 1'b1;
                rf_waddr = r_cnt;
                rf_wdata = r_mq;
                if (r_cnt == x) begin
                    n_i     = r_i + {12'd0, x} + 16'd1;
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 4'd1;
                    n_state = S_LD0;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (done) begin
            n_ov       = 1'b1;
            n_res_pc   = n_pc;
            n_res_i    = n_i;
            n_res_st   = d_status;
            n_res_beep = d_beep;
            n_res_rd   = d_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mq <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf[rf_waddr] <= rf_wdata;
        end
        r_rfq <= rf[rf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            fb[fb_waddr] <= fb_wdata;
        end
        r_fbq <= fb[fb_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_hi     <= n_hi;
        r_op     <= n_op;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_cnt    <= n_cnt;
        r_hit    <= n_hit;
        r_flag   <= n_flag;
        r_mask   <= n_mask;
        r_row    <= n_row;
        r_keys   <= n_keys;
        r_rnd    <= n_rnd;
        r_res_pc <= n_res_pc;
        r_res_i  <= n_res_i;
        r_res_st <= n_res_st;
        r_res_beep <= n_res_beep;
        r_res_rd <= n_res_rd;
        r_rfqv   <= r_rfv[rf_raddr];
        r_fbqv   <= r_fbv[fb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_icnt  <= 12'd0;
            r_pc    <= PC_RESET;
            r_i     <= 16'd0;
            r_sp    <= '0;
            r_delay <= 8'd0;
            r_sound <= 8'd0;
            r_ov    <= 1'b0;
            r_rfv   <= 16'd0;
            r_fbv   <= '0;
            for (int k = 0; k < STACK_DEPTH; k++) begin
                r_stack[k] <= 12'd0;
            end
        end else begin
            r_state <= n_state;
            r_icnt  <= r_icnt + 12'd1;
            r_pc    <= n_pc;
            r_i     <= n_i;
            r_sp    <= n_sp;
            r_delay <= n_delay;
            r_sound <= n_sound;
            r_ov    <= n_ov;
            if (rf_we) begin
                r_rfv[rf_waddr] <= 1'b1;
            end
            if (fbv_clear) begin
                r_fbv <= '0;
            end else if (fb_we) begin
                r_fbv[fb_waddr] <= 1'b1;
            end
            if (stack_we) begin
                r_stack[r_sp] <= r_pc;
            end
        end
    end

    assign o_enable                 = (r_state != S_INIT);
    assign o_result.valid           = r_ov;
    assign o_result.program_counter = r_res_pc;
    assign o_result.index_value     = r_res_i;
    assign o_result.status          = r_res_st;
    assign o_result.beep            = r_res_beep;
    assign o_result.read_data       = r_res_rd;

endmodule

// ===== src/chip8_interpreter_core_unit.sv =====
`timescale 1ns / 1ps
// CHIP-8 core top level: command intake queue feeding the execution sequencer.
// Throughput: one command at a time in the sequencer; a two-entry queue and the
// result register keep intake and delivery moving while it works.
// Reset: memory fill of all 4096 bytes (font, then zeros) with intake held off; PC 0x200.
module chip8_interpreter_core_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    chip8_in_if.sink     i_item,
    chip8_out_if.source  o_result
);
    import chip8_pkg::*;

    t_head w_head;
    logic  w_pop;
    logic  w_enable;

    chip8_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_enable (w_enable),
        .i_pop    (w_pop),
        .o_head   (w_head)
    );

    chip8_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_enable (w_enable),
        .o_result (o_result)
    );

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue popped while empty");

    a_no_intake_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_enable |-> !(i_item.valid && i_item.ready))
        else $error("transfer taken during memory fill");

    a_exec_fields_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != STS_DONE) |->
        (!o_result.beep && o_result.read_data == 8'd0))
        else $error("beep or read data set on an instruction result");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |=> o_result.valid)
        else $error("result dropped before transfer");

endmodule
